>>> rtl/dsmef_pkg.sv
// ----------------------------------------------------------------------------
// Depth stack fusion package
// Shared constants, types and the Gaussian lookup table.
// ----------------------------------------------------------------------------
package dsmef_pkg;

    localparam int MAX_STACK         = 16;
    localparam int GAUSS_TABLE_DEPTH = 256;
    localparam int GT_L  = $clog2(GAUSS_TABLE_DEPTH);
    localparam int CNT_W = $clog2(MAX_STACK + 1);
    localparam int EV_W  = 16 + $clog2(MAX_STACK);
    localparam int SZ_W  = 48 + $clog2(MAX_STACK);
    localparam int DV_W  = SZ_W;

    localparam logic [1:0] CFG_INV_SIGMA_WEIGHT = 2'd0;
    localparam logic [1:0] CFG_INV_SIGMA_DEPTH  = 2'd1;
    localparam logic [1:0] CFG_MAX_DIFFERENCE   = 2'd2;

    typedef logic [15:0] gauss_tab_t [GAUSS_TABLE_DEPTH];

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic fin;
    } pair_tag_t;

    typedef struct packed {
        logic ins;
        logic rot;
    } cell_ctl_t;

    function automatic gauss_tab_t gauss_build();
        gauss_tab_t  tab;
        logic [63:0] x30;
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        int          k;
        int          i;
        for (k = 0; k < GAUSS_TABLE_DEPTH; k++)
        begin
            x30  = (64'(k) << 34) / GAUSS_TABLE_DEPTH;
            y    = x30 >> 4;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (i = 1; i <= 12; i++)
            begin
                term = ((term * y) >> 30) / 64'(i);
                if (i % 2 == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = 64'(sum);
            for (i = 0; i < 4; i++)
            begin
                v = (v * v) >> 30;
            end
            tab[k] = 16'((v + 64'd16384) >> 15);
        end
        return tab;
    endfunction

    localparam gauss_tab_t GAUSS_TAB = gauss_build();

endpackage

>>> rtl/dsmef_cell.sv
// ----------------------------------------------------------------------------
// Stack cell
// Holds one candidate; shifts in on insertion and rotates during evaluation.
// ----------------------------------------------------------------------------
module dsmef_cell (
    input  logic                  clk,
    input  dsmef_pkg::cell_ctl_t  ctl,
    input  logic signed [31:0]    ins_depth,
    input  logic        [15:0]    ins_weight,
    input  logic signed [31:0]    rot_depth,
    input  logic        [15:0]    rot_weight,
    output logic signed [31:0]    depth,
    output logic        [15:0]    weight
);
    import dsmef_pkg::*;

    logic signed [31:0] depth_reg;
    logic        [15:0] weight_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.ins)
        begin
            depth_reg  <= ins_depth;
            weight_reg <= ins_weight;
        end
        else if (ctl.rot)
        begin
            depth_reg  <= rot_depth;
            weight_reg <= rot_weight;
        end
    end

    assign depth  = depth_reg;
    assign weight = weight_reg;

endmodule

>>> rtl/dsmef_pair.sv
// ----------------------------------------------------------------------------
// Pair term pipeline
// Gaussian support of one candidate pair and per-round accumulation.
// ----------------------------------------------------------------------------
module dsmef_pair (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dsmef_pkg::pair_tag_t      tag,
    input  logic signed [31:0]        zc,
    input  logic signed [31:0]        zk,
    input  logic        [15:0]        wk,
    input  logic        [23:0]        sig_w,
    input  logic        [23:0]        sig_z,
    input  logic        [31:0]        max_diff,
    output logic                      done,
    output logic                      done_fin,
    output logic signed [31:0]        done_zc,
    output logic [dsmef_pkg::EV_W-1:0] sp,
    output logic [dsmef_pkg::EV_W-1:0] spz,
    output logic signed [dsmef_pkg::SZ_W-1:0] sz
);
    import dsmef_pkg::*;

    pair_tag_t t1_reg, t2_reg, t3_reg, t4_reg, t5_reg, t6_reg;
    logic signed [31:0] zc1_reg, zc2_reg, zc3_reg, zc4_reg, zc5_reg, zc6_reg;
    logic signed [31:0] zk1_reg, zk2_reg, zk3_reg, zk4_reg, zk5_reg;
    logic [15:0] w1_reg, w2_reg, w3_reg, w4_reg;
    logic [31:0] d1_reg;
    logic        ok2_reg, bigw2_reg, bigz2_reg;
    logic [17:0] uw2_reg, uz2_reg;
    logic        zw3_reg, zz3_reg;
    logic [GT_L-1:0] iw3_reg, iz3_reg;
    logic [15:0] gw4_reg, gz4_reg;
    logic [15:0] pp5_reg, pz5_reg;
    logic [15:0] pp6_reg, pz6_reg;
    logic signed [47:0] pzk6_reg;
    logic        done_reg, fin_reg;
    logic signed [31:0] zcd_reg;
    logic [EV_W-1:0] sp_reg, spz_reg;
    logic signed [SZ_W-1:0] sz_reg;

    logic signed [32:0] diff;
    logic        [32:0] adiff;
    logic [55:0] prod_w, prod_z;
    logic [35:0] sq_w, sq_z;
    logic [31:0] m_w, m_z;
    logic signed [48:0] pzk;

    always_comb
    begin
        diff   = {zc[31], zc} - {zk[31], zk};
        adiff  = diff[32] ? (33'd0 - diff) : diff;
        prod_w = d1_reg * sig_w;
        prod_z = d1_reg * sig_z;
        sq_w   = uw2_reg * uw2_reg;
        sq_z   = uz2_reg * uz2_reg;
        m_w    = gw4_reg * w4_reg;
        m_z    = gz4_reg * w4_reg;
        pzk    = $signed({1'b0, pz5_reg}) * zk5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            t3_reg   <= '0;
            t4_reg   <= '0;
            t5_reg   <= '0;
            t6_reg   <= '0;
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else
        begin
            t1_reg   <= tag;
            t2_reg   <= t1_reg;
            t3_reg   <= t2_reg;
            t4_reg   <= t3_reg;
            t5_reg   <= t4_reg;
            t6_reg   <= t5_reg;
            done_reg <= t6_reg.valid && t6_reg.last;
            fin_reg  <= t6_reg.valid && t6_reg.last && t6_reg.fin;
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg   <= adiff[31:0];
        zc1_reg  <= zc;
        zk1_reg  <= zk;
        w1_reg   <= wk;

        ok2_reg   <= d1_reg < max_diff;
        bigw2_reg <= |prod_w[55:34];
        bigz2_reg <= |prod_z[55:34];
        uw2_reg   <= prod_w[33:16];
        uz2_reg   <= prod_z[33:16];
        zc2_reg   <= zc1_reg;
        zk2_reg   <= zk1_reg;
        w2_reg    <= w1_reg;

        zw3_reg <= bigw2_reg || !ok2_reg;
        zz3_reg <= bigz2_reg || !ok2_reg;
        iw3_reg <= sq_w[35 -: GT_L];
        iz3_reg <= sq_z[35 -: GT_L];
        zc3_reg <= zc2_reg;
        zk3_reg <= zk2_reg;
        w3_reg  <= w2_reg;

        gw4_reg <= zw3_reg ? 16'd0 : GAUSS_TAB[iw3_reg];
        gz4_reg <= zz3_reg ? 16'd0 : GAUSS_TAB[iz3_reg];
        zc4_reg <= zc3_reg;
        zk4_reg <= zk3_reg;
        w4_reg  <= w3_reg;

        pp5_reg <= m_w[30:15];
        pz5_reg <= m_z[30:15];
        zc5_reg <= zc4_reg;
        zk5_reg <= zk4_reg;

        pp6_reg  <= pp5_reg;
        pz6_reg  <= pz5_reg;
        pzk6_reg <= pzk[47:0];
        zc6_reg  <= zc5_reg;

        if (t6_reg.valid)
        begin
            if (t6_reg.first)
            begin
                sp_reg  <= EV_W'(pp6_reg);
                spz_reg <= EV_W'(pz6_reg);
                sz_reg  <= SZ_W'(pzk6_reg);
            end
            else
            begin
                sp_reg  <= sp_reg + EV_W'(pp6_reg);
                spz_reg <= spz_reg + EV_W'(pz6_reg);
                sz_reg  <= sz_reg + SZ_W'(pzk6_reg);
            end
            zcd_reg <= zc6_reg;
        end
    end

    assign done     = done_reg;
    assign done_fin = fin_reg;
    assign done_zc  = zcd_reg;
    assign sp       = sp_reg;
    assign spz      = spz_reg;
    assign sz       = sz_reg;

endmodule

>>> rtl/dsmef_div.sv
// ----------------------------------------------------------------------------
// Rounding divider
// Restoring division, one quotient bit per cycle, thirty-two quotient bits.
// ----------------------------------------------------------------------------
module dsmef_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dsmef_pkg::DV_W-1:0]  mag,
    input  logic [dsmef_pkg::EV_W-1:0]  divisor,
    output logic                        done,
    output logic [31:0]                 quot
);
    import dsmef_pkg::*;

    logic [5:0]      cnt_reg;
    logic            done_reg;
    logic [DV_W-1:0] rem_reg;
    logic [DV_W-1:0] dsr_reg;
    logic [31:0]     q_reg;
    logic            ge;

    assign ge = rem_reg >= dsr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cnt_reg == 6'd1;
            if (start)
            begin
                cnt_reg <= 6'd32;
            end
            else if (cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mag + DV_W'(divisor >> 1);
            dsr_reg <= DV_W'(divisor) << 31;
            q_reg   <= '0;
        end
        else if (cnt_reg != 6'd0)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsr_reg;
            end
            q_reg   <= {q_reg[30:0], ge};
            dsr_reg <= dsr_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

>>> rtl/depth_stack_max_evidence_fusion_top.sv
// ----------------------------------------------------------------------------
// Depth stack maximum-evidence fusion
// Stores a pixel's candidate stack in a ring of cells and picks the candidate
// with the largest Gaussian evidence, reporting its weighted mean depth.
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer when         Payload
// in        into       in_valid & !in_stall  depth_value, weight, last_candidate
// out       out of     out_valid & !out_stall fused_depth, best_evidence, flags
// cfg       into       cfg_write             cfg_index, cfg_data
//
// A candidate that does not end the stack does not stall the input.
// After a stack's last transfer, the ring rotation feeds each stored candidate pair
// to the single pair pipeline and the thirty-two step divider forms the mean, and
// only then does out_valid rise.
// Reset is asynchronous and active low; the stack starts empty.
// The input is stalled from the last candidate until the result is registered.
// ----------------------------------------------------------------------------
module depth_stack_max_evidence_fusion_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] depth_value,
    input  logic [15:0]        weight,
    input  logic               last_candidate,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] fused_depth,
    output logic [19:0]        best_evidence,
    output logic               has_value,
    output logic               stack_overflow
);
    import dsmef_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DGO   = 3'd3;
    localparam logic [2:0] ST_DIVW  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [23:0]      sig_w_reg, sig_z_reg;
    logic [31:0]      max_diff_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] k_reg, c_reg;
    logic signed [31:0] zc_reg;
    logic             have_reg;
    logic [EV_W-1:0]  best_ev_reg;
    logic [EV_W-1:0]  best_spz_reg;
    logic signed [31:0] best_z_reg;
    logic signed [SZ_W-1:0] best_sz_reg;
    logic             out_valid_reg;
    logic signed [31:0] fused_reg;
    logic [19:0]      ev_out_reg;
    logic             has_reg, ovf_out_reg;

    logic             accept, store, out_load;
    logic [15:0]      w_cl;
    cell_ctl_t        ctl;
    logic signed [31:0] cz [MAX_STACK];
    logic [15:0]      cw [MAX_STACK];
    pair_tag_t        tag;
    logic signed [31:0] zc_cur;
    logic             p_done, p_fin;
    logic signed [31:0] p_zc;
    logic [EV_W-1:0]  p_sp, p_spz, sp_eff;
    logic signed [SZ_W-1:0] p_sz;
    logic             better;
    logic [DV_W-1:0]  mag;
    logic             div_done;
    logic [31:0]      quot;
    logic [63:0]      ev_wide;
    logic [31:0]      mean;

    assign accept = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign w_cl = (weight > 16'd32768) ? 16'd32768 : weight;
    assign store = accept && (w_cl != 16'd0) && (count_reg < CNT_W'(MAX_STACK));
    assign ctl.ins = store;
    assign ctl.rot = state_reg == ST_EVAL;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_STACK; gi++)
        begin : g_cell
            logic signed [31:0] iz, rz;
            logic [15:0]        iw, rw;
            logic               wrap;
            if (gi == 0)
            begin : g_head
                assign iz = depth_value;
                assign iw = w_cl;
            end
            else
            begin : g_body
                assign iz = cz[gi-1];
                assign iw = cw[gi-1];
            end
            if (gi == MAX_STACK - 1)
            begin : g_tail
                assign wrap = 1'b1;
                assign rz = cz[0];
                assign rw = cw[0];
            end
            else
            begin : g_mid
                assign wrap = CNT_W'(gi) == count_reg - CNT_W'(1);
                assign rz = wrap ? cz[0] : cz[gi+1];
                assign rw = wrap ? cw[0] : cw[gi+1];
            end
            dsmef_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .ins_depth  (iz),
                .ins_weight (iw),
                .rot_depth  (rz),
                .rot_weight (rw),
                .depth      (cz[gi]),
                .weight     (cw[gi])
            );
        end
    endgenerate

    assign zc_cur    = (k_reg == '0) ? cz[0] : zc_reg;
    assign tag.valid = (state_reg == ST_EVAL) && (k_reg != count_reg);
    assign tag.first = k_reg == '0;
    assign tag.last  = k_reg == count_reg - CNT_W'(1);
    assign tag.fin   = c_reg == count_reg - CNT_W'(1);

    dsmef_pair u_pair (
        .clk      (clk),
        .rst_n    (rst_n),
        .tag      (tag),
        .zc       (zc_cur),
        .zk       (cz[0]),
        .wk       (cw[0]),
        .sig_w    (sig_w_reg),
        .sig_z    (sig_z_reg),
        .max_diff (max_diff_reg),
        .done     (p_done),
        .done_fin (p_fin),
        .done_zc  (p_zc),
        .sp       (p_sp),
        .spz      (p_spz),
        .sz       (p_sz)
    );

    assign sp_eff = (p_spz == '0) ? '0 : p_sp;
    assign better = !have_reg || (sp_eff > best_ev_reg)
                    || ((sp_eff == best_ev_reg) && (p_zc < best_z_reg));
    assign mag = best_sz_reg[SZ_W-1] ? DV_W'(-best_sz_reg) : DV_W'(best_sz_reg);

    dsmef_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_DGO),
        .mag     (mag),
        .divisor (best_spz_reg),
        .done    (div_done),
        .quot    (quot)
    );

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign ev_wide  = 64'(best_ev_reg);
    assign mean = (best_spz_reg == '0) ? 32'd0
                : (best_sz_reg[SZ_W-1] ? (32'd0 - quot) : quot);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (store)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (accept && (w_cl != 16'd0))
        begin
            ovf_next = 1'b1;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_candidate)
                begin
                    state_next = (count_next == '0) ? ST_OUT : ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if ((k_reg == count_reg) && (c_reg == count_reg - CNT_W'(1)))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (p_done && p_fin)
                begin
                    state_next = ST_DGO;
                end
            end
            ST_DGO:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            c_reg         <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            sig_w_reg     <= 24'd65536;
            sig_z_reg     <= 24'd65536;
            max_diff_reg  <= 32'hFFFF_FFFF;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_INV_SIGMA_WEIGHT: sig_w_reg    <= cfg_data[23:0];
                    CFG_INV_SIGMA_DEPTH:  sig_z_reg    <= cfg_data[23:0];
                    CFG_MAX_DIFFERENCE:   max_diff_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (accept && last_candidate)
            begin
                k_reg    <= '0;
                c_reg    <= '0;
                have_reg <= 1'b0;
            end
            else if (state_reg == ST_EVAL)
            begin
                if (k_reg == count_reg)
                begin
                    k_reg <= '0;
                    c_reg <= c_reg + CNT_W'(1);
                end
                else
                begin
                    k_reg <= k_reg + CNT_W'(1);
                end
            end
            if (p_done && better)
            begin
                have_reg <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_EVAL) && (k_reg == '0))
        begin
            zc_reg <= cz[0];
        end
        if (p_done && better)
        begin
            best_ev_reg  <= sp_eff;
            best_spz_reg <= p_spz;
            best_z_reg   <= p_zc;
            best_sz_reg  <= p_sz;
        end
        if (out_load)
        begin
            fused_reg   <= have_reg ? mean : 32'd0;
            ev_out_reg  <= !have_reg ? 20'd0
                         : ((ev_wide > 64'hF_FFFF) ? 20'hF_FFFF : ev_wide[19:0]);
            has_reg     <= have_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fused_depth    = fused_reg;
    assign best_evidence  = ev_out_reg;
    assign has_value      = has_reg;
    assign stack_overflow = ovf_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_STACK))
        else $error("stack count beyond capacity");

    a_fin_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (p_done && p_fin) |-> (state_reg == ST_DRAIN))
        else $error("final round completed outside drain");

    a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised without a finished stack");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVW))
        else $error("divider finished outside its wait");

endmodule

>>> test/tb_depth_stack_max_evidence_fusion_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Depth stack maximum-evidence fusion testbench
// Sends pixel stacks of candidates under several register settings, predicts
// each fused result and compares every output transfer with the oldest one.
// ----------------------------------------------------------------------------
module tb_depth_stack_max_evidence_fusion_top;
    import dsmef_pkg::*;

    typedef struct {
        logic signed [31:0] depth;
        logic [19:0]        evidence;
        logic               has;
        logic               ovf;
    } fusion_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] depth_value;
    logic [15:0]        weight;
    logic               last_candidate;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] fused_depth;
    logic [19:0]        best_evidence;
    logic               has_value;
    logic               stack_overflow;

    logic [15:0]        exp_tab [GAUSS_TABLE_DEPTH];
    logic [23:0]        sig_w;
    logic [23:0]        sig_z;
    logic [31:0]        diff_limit;
    logic signed [31:0] cand_depth [MAX_STACK];
    logic [15:0]        cand_weight [MAX_STACK];
    int                 cand_count;
    logic               cand_dropped;
    fusion_t            expected_fusion [$];
    int                 fail_count;
    int                 item_count;
    logic               calm;
    logic               hold_go;
    logic               hold_done;
    int                 hold_left;

    depth_stack_max_evidence_fusion_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .depth_value    (depth_value),
        .weight         (weight),
        .last_candidate (last_candidate),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .fused_depth    (fused_depth),
        .best_evidence  (best_evidence),
        .has_value      (has_value),
        .stack_overflow (stack_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #8000000;
        $display("tb_depth_stack_max_evidence_fusion_top failed");
        $finish;
    end

    function automatic void build_exp_table();
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] v;
        longint      acc;
        for (int k = 0; k < GAUSS_TABLE_DEPTH; k++)
        begin
            x   = ((64'(k) << 34) / GAUSS_TABLE_DEPTH) >> 4;
            t   = 64'd1 << 30;
            acc = longint'(t);
            for (int i = 1; i <= 12; i++)
            begin
                t = ((t * x) >> 30) / 64'(i);
                if (i % 2 == 1)
                begin
                    acc = acc - longint'(t);
                end
                else
                begin
                    acc = acc + longint'(t);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            v = 64'(acc);
            for (int i = 0; i < 4; i++)
            begin
                v = (v * v) >> 30;
            end
            exp_tab[k] = 16'((v + 64'd16384) >> 15);
        end
    endfunction

    function automatic logic [15:0] gauss_lookup(logic [63:0] span, logic [23:0] inv);
        logic [63:0] u;
        logic [63:0] idx;
        u = (span * 64'(inv)) >> 16;
        if (u >= (64'd4 << 16))
        begin
            return 16'd0;
        end
        idx = (u * u * GAUSS_TABLE_DEPTH) >> 36;
        if (idx >= GAUSS_TABLE_DEPTH)
        begin
            return 16'd0;
        end
        return exp_tab[idx];
    endfunction

    function automatic fusion_t fuse_stack();
        fusion_t     r;
        logic        have;
        logic [63:0] best_ev;
        longint      best_z;
        longint      best_mean;
        logic [63:0] sp;
        logic [63:0] spz;
        logic [63:0] pz;
        logic [63:0] span;
        logic [63:0] mag;
        logic [63:0] q;
        longint      sz;
        longint      mean;
        longint      d;
        have      = 1'b0;
        best_ev   = 0;
        best_z    = 0;
        best_mean = 0;
        for (int c = 0; c < cand_count; c++)
        begin
            sp   = 0;
            spz  = 0;
            sz   = 0;
            mean = 0;
            for (int k = 0; k < cand_count; k++)
            begin
                d    = longint'(cand_depth[c]) - longint'(cand_depth[k]);
                span = 64'(d < 0 ? -d : d);
                if (span < 64'(diff_limit))
                begin
                    sp  = sp + ((64'(gauss_lookup(span, sig_w)) * cand_weight[k]) >> 15);
                    pz  = (64'(gauss_lookup(span, sig_z)) * cand_weight[k]) >> 15;
                    spz = spz + pz;
                    sz  = sz + longint'(pz) * longint'(cand_depth[k]);
                end
            end
            if (spz > 0)
            begin
                mag  = sz < 0 ? 64'(-sz) : 64'(sz);
                q    = (mag + spz / 2) / spz;
                mean = sz < 0 ? -longint'(q) : longint'(q);
            end
            else
            begin
                sp = 0;
            end
            if (!have || sp > best_ev || (sp == best_ev && longint'(cand_depth[c]) < best_z))
            begin
                have      = 1'b1;
                best_ev   = sp;
                best_z    = cand_depth[c];
                best_mean = mean;
            end
        end
        r.depth    = have ? 32'(best_mean) : 32'd0;
        r.evidence = have ? (best_ev > 64'hFFFFF ? 20'hFFFFF : 20'(best_ev)) : 20'd0;
        r.has      = have;
        r.ovf      = cand_dropped;
        return r;
    endfunction

    task automatic send_candidate(logic signed [31:0] z, logic [15:0] w, logic fin);
        logic [15:0] wc;
        while (!calm && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        depth_value    <= z;
        weight         <= w;
        last_candidate <= fin;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        item_count++;
        wc = w > 16'd32768 ? 16'd32768 : w;
        if (wc != 0)
        begin
            if (cand_count < MAX_STACK)
            begin
                cand_depth[cand_count]  = z;
                cand_weight[cand_count] = wc;
                cand_count++;
            end
            else
            begin
                cand_dropped = 1'b1;
            end
        end
        if (fin)
        begin
            expected_fusion = {expected_fusion, fuse_stack()};
            cand_count   = 0;
            cand_dropped = 1'b0;
        end
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (expected_fusion.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_INV_SIGMA_WEIGHT: sig_w = val[23:0];
            CFG_INV_SIGMA_DEPTH:  sig_z = val[23:0];
            default:              diff_limit = val;
        endcase
    endtask

    task automatic set_regs(logic [23:0] sw, logic [23:0] sz, logic [31:0] md);
        wait_quiet();
        write_reg(CFG_INV_SIGMA_WEIGHT, {8'd0, sw});
        write_reg(CFG_INV_SIGMA_DEPTH, {8'd0, sz});
        write_reg(CFG_MAX_DIFFERENCE, md);
    endtask

    task automatic random_stack(int spread);
        int                 len;
        logic signed [31:0] base;
        logic signed [31:0] z;
        logic [15:0]        w;
        len  = ($urandom_range(99) < 8) ? $urandom_range(17, 20) : $urandom_range(1, 10);
        base = $urandom;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(9))
                0:       z = $urandom;
                1:       z = base;
                default: z = base + $signed($urandom_range(2 * spread)) - spread;
            endcase
            case ($urandom_range(9))
                0:       w = 16'd0;
                1:       w = 16'd32768;
                2:       w = 16'($urandom);
                default: w = 16'($urandom_range(1, 32768));
            endcase
            send_candidate(z, w, i == len - 1);
        end
    endtask

    task automatic test_directed();
        send_candidate(32'sh7FFFFFFF, 16'd32768, 1'b0);
        send_candidate(-32'sh80000000, 16'hFFFF, 1'b0);
        send_candidate(32'sd0, 16'd1, 1'b1);
        send_candidate(32'sd0, 16'd0, 1'b1);
        send_candidate(32'sd65536, 16'd16384, 1'b0);
        send_candidate(-32'sd65536, 16'd16384, 1'b0);
        send_candidate(32'sd100, 16'd0, 1'b1);
        for (int i = 0; i < 17; i++)
        begin
            send_candidate(32'sd1000 * i, 16'd20000, i == 16);
        end
    endtask

    task automatic test_limit_zero();
        set_regs(24'd65536, 24'd65536, 32'd0);
        send_candidate(32'sd500, 16'd1000, 1'b0);
        send_candidate(-32'sd500, 16'd1000, 1'b0);
        send_candidate(32'sd500, 16'd1000, 1'b1);
    endtask

    task automatic test_random_settings();
        int target;
        target = item_count + 700;
        while (item_count < target)
        begin
            case ($urandom_range(4))
                0:       set_regs(24'd1, 24'hFFFFFF, 32'hFFFFFFFF);
                1:       set_regs(24'hFFFFFF, 24'd1, $urandom_range(1, 200000));
                2:       set_regs(24'd65536, 24'd65536, 32'hFFFFFFFF);
                default: set_regs(24'($urandom_range(1, 24'hFFFFFF)),
                                  24'($urandom_range(1, 24'hFFFFFF)), $urandom);
            endcase
            calm = ($urandom_range(5) == 0);
            for (int s = 0; s < 10; s++)
            begin
                random_stack($urandom_range(99) < 50 ? 200000 : 4000);
            end
            calm = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        set_regs(24'd65536, 24'd32768, 32'hFFFFFFFF);
        hold_go = 1'b1;
        for (int s = 0; s < 6; s++)
        begin
            random_stack(100000);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_fusion.size() == 0)
            begin
                $error("unexpected output transfer");
                fail_count++;
            end
            else
            begin
                if (fused_depth !== expected_fusion[0].depth)
                begin
                    $error("fused_depth expected %0d actual %0d",
                           expected_fusion[0].depth, fused_depth);
                    fail_count++;
                end
                if (best_evidence !== expected_fusion[0].evidence)
                begin
                    $error("best_evidence expected %0d actual %0d",
                           expected_fusion[0].evidence, best_evidence);
                    fail_count++;
                end
                if (has_value !== expected_fusion[0].has)
                begin
                    $error("has_value expected %0b actual %0b",
                           expected_fusion[0].has, has_value);
                    fail_count++;
                end
                if (stack_overflow !== expected_fusion[0].ovf)
                begin
                    $error("stack_overflow expected %0b actual %0b",
                           expected_fusion[0].ovf, stack_overflow);
                    fail_count++;
                end
                void'(expected_fusion.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !calm && ($urandom_range(99) < 31);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_INV_SIGMA_WEIGHT;
        cfg_data       = 32'd0;
        in_valid       = 1'b0;
        depth_value    = 32'sd0;
        weight         = 16'd0;
        last_candidate = 1'b0;
        out_stall      = 1'b0;
        calm           = 1'b0;
        hold_go        = 1'b0;
        hold_done      = 1'b0;
        hold_left      = 0;
        fail_count     = 0;
        item_count     = 0;
        cand_count     = 0;
        cand_dropped   = 1'b0;
        sig_w          = 24'd65536;
        sig_z          = 24'd65536;
        diff_limit     = 32'hFFFFFFFF;
        build_exp_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limit_zero();
        test_random_settings();
        test_backpressure();
        wait_quiet();

        if (fail_count == 0 && expected_fusion.size() == 0)
        begin
            $display("tb_depth_stack_max_evidence_fusion_top passed");
        end
        else
        begin
            $display("tb_depth_stack_max_evidence_fusion_top failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/dsmef_pkg.sv
rtl/dsmef_cell.sv
rtl/dsmef_pair.sv
rtl/dsmef_div.sv
rtl/depth_stack_max_evidence_fusion_top.sv
test/tb_depth_stack_max_evidence_fusion_top.sv
